### rtl/arsch_pkg.sv
package arsch_pkg;

    // Field widths of the command and result words
    localparam int IDX_W  = 4;
    localparam int TIME_W = 16;
    localparam int ACT_W  = 5;
    localparam int QNT_W  = 8;

    // Divider widths: numerator 2a+b, denominator 2b
    localparam int DIV_NUM_W = 19;
    localparam int DIV_DEN_W = 17;

    localparam logic [TIME_W-1:0] PRIO_MAX = 16'hFFFF;

    // Command codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_SETREM = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_POLICY = 2'd3;

    // Entry status codes
    localparam logic [1:0] ST_NEW      = 2'd0;
    localparam logic [1:0] ST_READY    = 2'd1;
    localparam logic [1:0] ST_RUNNING  = 2'd2;
    localparam logic [1:0] ST_FINISHED = 2'd3;

    // Configuration register indexes
    localparam logic REG_ACTIVE  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    typedef struct packed {
        logic [1:0]        status;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  entry_index;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_length;
        logic [TIME_W-1:0] initial_priority;
        logic [TIME_W-1:0] remaining_value;
        logic [TIME_W-1:0] tick_time;
    } cmd_word_t;

    typedef struct packed {
        logic             selected_valid;
        logic [IDX_W-1:0] selected_index;
        logic             first_dispatch;
        logic             finished_valid;
        logic [IDX_W-1:0] finished_index;
    } res_word_t;

endpackage

### rtl/arsch_table.sv
module arsch_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
    output arsch_pkg::entry_t              rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
    input  arsch_pkg::entry_t              wr_data
);
    import arsch_pkg::*;

    entry_t                 mem_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;
    entry_t                 rd_word_reg;
    logic                   rd_ok_reg;

    // Entry storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem_reg[rd_addr];
        end
    end

    // Written marks: an entry never written reads as all zero (status NEW)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_ok_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_word_reg : '0;

endmodule

### rtl/arsch_div.sv
module arsch_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [arsch_pkg::DIV_NUM_W-1:0]  num,
    input  logic [arsch_pkg::DIV_DEN_W-1:0]  den,
    output logic                             done,
    output logic [arsch_pkg::DIV_NUM_W-1:0]  quo
);
    import arsch_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic [DIV_DEN_W:0]   shifted;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[DIV_NUM_W-1]};
        if (start)
        begin
            rem_next = '0;
            quo_next = num;
            den_next = den;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = DIV_DEN_W'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIV_DEN_W-1:0];
                quo_next = {quo_reg[DIV_NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### rtl/aging_priority_rr_scheduler.sv
// Aging-priority round-robin scheduler over a table of task entries.
// Command channel: a word on cmd is taken when start is high and busy is low;
// busy stays high until the result word is shown. Every command gives one
// result word on result, marked by done for one cycle; the receiver cannot
// stall, so the result is simply presented and the block returns to idle.
// Configuration: cfg_index 0 is active_count, 1 is slice_quantum; writes are
// always accepted (cfg_ready high) and belong in idle periods.
// Load writes the entry; set remaining reads and rewrites it. Tick: a walk
// over the active entries, each read, evaluated and written back (a live
// entry waits for the bit-serial divider on an aging tick), one read of the
// running entry, then a round-robin walk. All entry state sits in one table
// memory with one read and one write port, so one entry is handled at a
// time; a new command is taken only after the previous result.
// Reset: all entries read as NEW, nothing runs, active_count is 16 and
// slice_quantum is 2; no clearing pass is needed.
module aging_priority_rr_scheduler #(
    parameter int TABLE_DEPTH  = 16,
    parameter int AGING_PERIOD = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  arsch_pkg::cmd_word_t              cmd,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [arsch_pkg::QNT_W-1:0]       cfg_data,
    output logic                              done,
    output arsch_pkg::res_word_t              result
);
    import arsch_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = AW + 1;

    // Reciprocal of the aging period for the tick-time remainder
    localparam int AGE_SH = TIME_W + $clog2(AGING_PERIOD);
    localparam int AGE_MW = TIME_W + 1;
    localparam logic [AGE_MW-1:0] AGE_MUL =
        AGE_MW'(((longint'(1) << AGE_SH) + longint'(AGING_PERIOD) - 1) /
                longint'(AGING_PERIOD));

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LOAD  = 4'd1;
    localparam logic [3:0] S_SR_RD = 4'd2;
    localparam logic [3:0] S_SR_WR = 4'd3;
    localparam logic [3:0] S_A_RD  = 4'd4;
    localparam logic [3:0] S_A_EV  = 4'd5;
    localparam logic [3:0] S_A_DIV = 4'd6;
    localparam logic [3:0] S_A_WR  = 4'd7;
    localparam logic [3:0] S_R_CHK = 4'd8;
    localparam logic [3:0] S_R_EV  = 4'd9;
    localparam logic [3:0] S_MOD   = 4'd10;
    localparam logic [3:0] S_B_RD  = 4'd11;
    localparam logic [3:0] S_B_EV  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]        state_reg, state_next;
    cmd_word_t         cmd_reg, cmd_next;
    logic [CW-1:0]     n_reg, n_next;
    logic              age_reg, age_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [TIME_W-1:0] best_reg, best_next;
    logic              any_reg, any_next;
    entry_t            work_reg, work_next;
    logic              live_reg, live_next;
    logic              run_valid_reg, run_valid_next;
    logic [AW-1:0]     run_slot_reg, run_slot_next;
    logic [QNT_W-1:0]  slice_reg, slice_next;
    logic              last_valid_reg, last_valid_next;
    logic [AW-1:0]     last_pick_reg, last_pick_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    res_word_t         res_reg, res_next;
    logic [ACT_W-1:0]  active_reg;
    logic [QNT_W-1:0]  quantum_reg;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    entry_t            wr_data;
    logic              div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic              div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic [1:0]        st_upd;
    logic              ev_live;
    logic signed [18:0] wait_raw;
    logic [17:0]       wait_clamp;
    logic [17:0]       sum_a;

    logic [TIME_W+AGE_MW-1:0] age_prod;
    logic [TIME_W-1:0]        age_quo;
    logic                     age_hit;

    arsch_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    arsch_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Aging tick: nonzero tick time that is a multiple of the period
    always_comb
    begin
        age_prod = (TIME_W+AGE_MW)'(cmd.tick_time) * (TIME_W+AGE_MW)'(AGE_MUL);
        age_quo  = TIME_W'(age_prod >> AGE_SH);
        age_hit  = (cmd.tick_time != '0) &&
                   (cmd.tick_time == TIME_W'(age_quo * AGING_PERIOD));
    end

    // Entry evaluation on the word just read
    always_comb
    begin
        st_upd = rd_data.status;
        if (rd_data.status == ST_NEW && rd_data.arrival <= cmd_reg.tick_time)
        begin
            st_upd = ST_READY;
        end
        ev_live = (st_upd == ST_READY || st_upd == ST_RUNNING) &&
                  (rd_data.remaining != '0);
        wait_raw = $signed({3'b000, cmd_reg.tick_time}) - $signed({3'b000, rd_data.arrival})
                 - $signed({3'b000, rd_data.burst}) + $signed({3'b000, rd_data.remaining});
        wait_clamp = wait_raw[18] ? '0 : wait_raw[17:0];
        sum_a      = wait_clamp + {2'b00, rd_data.remaining};
        div_num    = {sum_a, 1'b0} + {3'b000, rd_data.remaining};
        div_den    = {rd_data.remaining, 1'b0};
    end

    // Command sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        n_next          = n_reg;
        age_next        = age_reg;
        i_next          = i_reg;
        best_next       = best_reg;
        any_next        = any_reg;
        work_next       = work_reg;
        live_next       = live_reg;
        run_valid_next  = run_valid_reg;
        run_slot_next   = run_slot_reg;
        slice_next      = slice_reg;
        last_valid_next = last_valid_reg;
        last_pick_next  = last_pick_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data;
        div_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = cmd;
                    res_next = '0;
                    unique case (cmd.op)
                        OP_LOAD:   state_next = S_LOAD;
                        OP_SETREM: state_next = S_SR_RD;
                        OP_TICK:
                        begin
                            n_next   = (32'(active_reg) > TABLE_DEPTH) ?
                                       CW'(TABLE_DEPTH) : CW'(active_reg);
                            age_next = age_hit;
                            i_next   = '0;
                            best_next = '0;
                            any_next  = 1'b0;
                            state_next = S_A_RD;
                        end
                        OP_POLICY:
                        begin
                            run_valid_next  = 1'b0;
                            run_slot_next   = '0;
                            slice_next      = '0;
                            last_valid_next = 1'b0;
                            last_pick_next  = '0;
                            state_next      = S_DONE;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_LOAD:
            begin
                wr_en = (32'(cmd_reg.entry_index) < TABLE_DEPTH);
                wr_addr = AW'(cmd_reg.entry_index);
                wr_data.status    = ST_NEW;
                wr_data.arrival   = cmd_reg.arrival_time;
                wr_data.burst     = cmd_reg.burst_length;
                wr_data.remaining = cmd_reg.burst_length;
                wr_data.prio      = cmd_reg.initial_priority;
                state_next = S_DONE;
            end
            S_SR_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(cmd_reg.entry_index);
                state_next = S_SR_WR;
            end
            S_SR_WR:
            begin
                wr_en   = (32'(cmd_reg.entry_index) < TABLE_DEPTH);
                wr_addr = AW'(cmd_reg.entry_index);
                wr_data.remaining = cmd_reg.remaining_value;
                state_next = S_DONE;
            end
            // Pass one: arrivals, aging and the top live priority
            S_A_RD:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = S_R_CHK;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = i_reg[AW-1:0];
                    state_next = S_A_EV;
                end
            end
            S_A_EV:
            begin
                work_next        = rd_data;
                work_next.status = st_upd;
                live_next        = ev_live;
                if (age_reg && ev_live)
                begin
                    div_start  = 1'b1;
                    state_next = S_A_DIV;
                end
                else
                begin
                    state_next = S_A_WR;
                end
            end
            S_A_DIV:
            begin
                if (div_done)
                begin
                    work_next.prio = (div_quo > DIV_NUM_W'(PRIO_MAX)) ?
                                     PRIO_MAX : div_quo[TIME_W-1:0];
                    state_next = S_A_WR;
                end
            end
            S_A_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg[AW-1:0];
                wr_data = work_reg;
                if (live_reg && (!any_reg || work_reg.prio > best_reg))
                begin
                    best_next = work_reg.prio;
                    any_next  = 1'b1;
                end
                i_next     = i_reg + 1'b1;
                state_next = S_A_RD;
            end
            // Running entry check
            S_R_CHK:
            begin
                k_next = last_valid_reg ? (CW'(last_pick_reg) + 1'b1) : '0;
                if (!any_reg)
                begin
                    run_valid_next = 1'b0;
                    state_next     = S_DONE;
                end
                else if (run_valid_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = run_slot_reg;
                    state_next = S_R_EV;
                end
                else
                begin
                    state_next = S_MOD;
                end
            end
            S_R_EV:
            begin
                wr_addr    = run_slot_reg;
                state_next = S_MOD;
                if (rd_data.remaining == '0)
                begin
                    wr_en          = 1'b1;
                    wr_data.status = ST_FINISHED;
                    res_next.finished_valid = 1'b1;
                    res_next.finished_index = IDX_W'(run_slot_reg);
                    run_valid_next = 1'b0;
                    slice_next     = '0;
                end
                else if (rd_data.prio < best_reg)
                begin
                    wr_en          = 1'b1;
                    wr_data.status = ST_READY;
                    run_valid_next = 1'b0;
                    slice_next     = '0;
                end
                else if (rd_data.prio == best_reg)
                begin
                    if (slice_reg >= quantum_reg)
                    begin
                        wr_en          = 1'b1;
                        wr_data.status = ST_READY;
                        run_valid_next = 1'b0;
                        slice_next     = '0;
                    end
                    else
                    begin
                        slice_next = slice_reg + 1'b1;
                        res_next.selected_valid = 1'b1;
                        res_next.selected_index = IDX_W'(run_slot_reg);
                        state_next = S_DONE;
                    end
                end
            end
            // Wrap the round-robin start into the active range
            S_MOD:
            begin
                if (k_reg >= n_reg)
                begin
                    k_next = k_reg - n_reg;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_B_RD;
                end
            end
            // Pass two: first top-priority live entry after the last pick
            S_B_RD:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = k_reg[AW-1:0];
                    state_next = S_B_EV;
                end
            end
            S_B_EV:
            begin
                if ((rd_data.status == ST_READY || rd_data.status == ST_RUNNING) &&
                    rd_data.remaining != '0 && rd_data.prio == best_reg)
                begin
                    wr_en          = 1'b1;
                    wr_addr        = k_reg[AW-1:0];
                    wr_data.status = ST_RUNNING;
                    run_valid_next  = 1'b1;
                    run_slot_next   = k_reg[AW-1:0];
                    last_valid_next = 1'b1;
                    last_pick_next  = k_reg[AW-1:0];
                    slice_next      = QNT_W'(1);
                    res_next.selected_valid = 1'b1;
                    res_next.selected_index = IDX_W'(k_reg[AW-1:0]);
                    res_next.first_dispatch = (rd_data.burst == rd_data.remaining);
                    state_next = S_DONE;
                end
                else
                begin
                    k_next     = (k_reg + 1'b1 == n_reg) ? '0 : k_reg + 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_B_RD;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            run_valid_reg  <= 1'b0;
            run_slot_reg   <= '0;
            slice_reg      <= '0;
            last_valid_reg <= 1'b0;
            last_pick_reg  <= '0;
            any_reg        <= 1'b0;
            live_reg       <= 1'b0;
            age_reg        <= 1'b0;
            n_reg          <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            run_valid_reg  <= run_valid_next;
            run_slot_reg   <= run_slot_next;
            slice_reg      <= slice_next;
            last_valid_reg <= last_valid_next;
            last_pick_reg  <= last_pick_next;
            any_reg        <= any_next;
            live_reg       <= live_next;
            age_reg        <= age_next;
            n_reg          <= n_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            res_reg        <= res_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        work_reg <= work_next;
        best_reg <= best_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= ACT_W'(16);
            quantum_reg <= QNT_W'(2);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ACTIVE:  active_reg  <= cfg_data[ACT_W-1:0];
                REG_QUANTUM: quantum_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = (state_reg != S_IDLE);
    assign done      = (state_reg == S_DONE);
    assign result    = res_reg;

endmodule
